// ===== hw/rtl/priority_ticket_table_macros.svh =====
// assertion helpers for the ticket table, sampled on clk and masked in reset
`ifndef PRIORITY_TICKET_TABLE_MACROS_SVH
`define PRIORITY_TICKET_TABLE_MACROS_SVH

// same-cycle check: antecedent implies consequent
`define PTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle check: antecedent implies consequent
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ptt_pkg.sv =====
package ptt_pkg;

	// field widths fixed by the item format
	localparam int KEY_W    = 64;
	localparam int CLIENT_W = 32;
	localparam int PRI_W    = 2;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;
	localparam int FUNC_W   = 3;
	localparam int STATUS_W = 3;

	// function codes
	localparam logic [FUNC_W-1:0] FN_ADD      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_LOOKUP   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_LIST_PRI = 3'd3;
	localparam logic [FUNC_W-1:0] FN_LIST_ALL = 3'd4;

	// priority range
	localparam logic [PRI_W-1:0] PRI_NONE = 2'd0;
	localparam logic [PRI_W-1:0] PRI_HIGH = 2'd1;
	localparam logic [PRI_W-1:0] PRI_LOW  = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_DUP      = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_BADPRI   = 3'd5
	} status_t;

	// one stored ticket
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [CLIENT_W-1:0] client;
		logic [PRI_W-1:0]    pri;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/priority_ticket_table.sv =====
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// input    | in_valid, in_stall | func, key, client_id, priority_in
// output   | out_valid, out_stall | status, entry_key, entry_client, entry_priority,
//          |                    | position, entry_count, last
//
// storage: the table sits in one memory, read one entry a cycle unless out_stall
// holds a listing walk; add, remove and lookup scan for the key, remove then moves
// later entries down, list all walks once, list by priority up to once per priority;
// rejected and empty-table items skip the walk, as does an add to an empty table.
// reset: clears the entry count and the control state; memory contents are not
// cleared, entries at or above the count are never read.
// stalls: out_stall holds a listing walk at an entry to be emitted; one finished
// result waits in the output register while the next item is taken.
`include "priority_ticket_table_macros.svh"

module priority_ticket_table
	import ptt_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [FUNC_W-1:0]   func,
	input  logic [KEY_W-1:0]    key,
	input  logic [CLIENT_W-1:0] client_id,
	input  logic [PRI_W-1:0]    priority_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [KEY_W-1:0]    entry_key,
	output logic [CLIENT_W-1:0] entry_client,
	output logic [PRI_W-1:0]    entry_priority,
	output logic [POS_W-1:0]    position,
	output logic [COUNT_W-1:0]  entry_count,
	output logic                last
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_APPEND,
		S_LIST,
		S_RESP
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  valid_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [IDX_W-1:0]      pos_q;
	logic [PRI_W-1:0]      pass_q;
	logic [FUNC_W-1:0]     func_q;
	logic [KEY_W-1:0]      key_q;
	logic [CLIENT_W-1:0]   client_q;
	logic [PRI_W-1:0]      pri_q;
	status_t               res_status_q;
	entry_t                res_entry_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	entry_t                out_entry_q;
	logic [IDX_W-1:0]      out_pos_q;
	logic [CNT_W-1:0]      out_count_q;
	logic                  out_last_q;

	entry_t                rd_entry;
	entry_t                wr_entry;
	logic [ENTRY_W-1:0]    rd_data;
	logic                  ram_rd_en;
	logic                  ram_wr_en;
	logic [IDX_W-1:0]      ram_wr_addr;

	logic                  out_free;
	logic [IDX_W-1:0]      last_idx;
	logic                  s1_last;
	logic                  key_hit;
	logic                  pass_hit;
	logic                  list_adv;
	logic                  list_emit;
	logic                  list_final;
	logic                  rd_more;
	logic                  accept;

	// entry memory
	ptt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(wr_entry),
		.rd_en  (ram_rd_en),
		.rd_addr(rd_idx_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	assign rd_entry = entry_t'(rd_data);

	// walk control and compare
	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		accept     = (state_q == S_IDLE) && in_valid;
		last_idx   = IDX_W'(count_q - CNT_W'(1));
		s1_last    = valid_s1 && (idx_s1 == last_idx);
		key_hit    = valid_s1 && (rd_entry.key == key_q);
		pass_hit   = (pass_q == PRI_NONE) || (rd_entry.pri == pass_q);
		list_adv   = !valid_s1 || !pass_hit || out_free;
		list_emit  = (state_q == S_LIST) && valid_s1 && pass_hit && out_free;
		list_final = (CNT_W'(pos_q) + CNT_W'(1)) == count_q;
		rd_more    = rd_idx_q < count_q;
		ram_rd_en  = rd_more && ((state_q == S_SCAN) || (state_q == S_SHIFT) ||
			((state_q == S_LIST) && list_adv));
	end

	// writes: append at the end, or move an entry down one slot
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = count_q[IDX_W-1:0];
		wr_entry    = '{key: key_q, client: client_q, pri: pri_q};
		if (state_q == S_APPEND) begin
			ram_wr_en = 1'b1;
		end else if ((state_q == S_SHIFT) && valid_s1) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = idx_s1 - IDX_W'(1);
			wr_entry    = rd_entry;
		end
	end

	// sequencer, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			pos_q        <= '0;
			pass_q       <= PRI_NONE;
			out_valid_q  <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ram_rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					valid_s1 <= 1'b0;
					rd_idx_q <= '0;
					pos_q    <= '0;
					if (accept) begin
						func_q       <= func;
						key_q        <= key;
						client_q     <= client_id;
						pri_q        <= priority_in;
						res_entry_q  <= '0;
						res_status_q <= ST_EMPTY;
						case (func)
							FN_ADD: begin
								if (count_q >= CNT_W'(CAPACITY)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_RESP;
								end else if (priority_in == PRI_NONE) begin
									res_status_q <= ST_BADPRI;
									state_q      <= S_RESP;
								end else if (count_q == '0) begin
									state_q <= S_APPEND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							FN_REMOVE, FN_LOOKUP: begin
								state_q <= (count_q == '0) ? S_RESP : S_SCAN;
							end
							FN_LIST_PRI: begin
								pass_q  <= PRI_HIGH;
								state_q <= (count_q == '0) ? S_RESP : S_LIST;
							end
							FN_LIST_ALL: begin
								pass_q  <= PRI_NONE;
								state_q <= (count_q == '0) ? S_RESP : S_LIST;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					valid_s1 <= ram_rd_en;
					idx_s1   <= rd_idx_q[IDX_W-1:0];
					if (key_hit) begin
						valid_s1 <= 1'b0;
						case (func_q)
							FN_ADD: begin
								res_status_q <= ST_DUP;
								state_q      <= S_RESP;
							end
							FN_REMOVE: begin
								res_status_q <= ST_OK;
								res_entry_q  <= rd_entry;
								rd_idx_q     <= CNT_W'(idx_s1) + CNT_W'(1);
								if (s1_last) begin
									count_q <= count_q - CNT_W'(1);
									state_q <= S_RESP;
								end else begin
									state_q <= S_SHIFT;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								res_entry_q  <= rd_entry;
								state_q      <= S_RESP;
							end
						endcase
					end else if (s1_last) begin
						valid_s1 <= 1'b0;
						if (func_q == FN_ADD) begin
							state_q <= S_APPEND;
						end else begin
							res_status_q <= ST_NOTFOUND;
							state_q      <= S_RESP;
						end
					end
				end
				S_SHIFT: begin
					valid_s1 <= ram_rd_en;
					idx_s1   <= rd_idx_q[IDX_W-1:0];
					if (s1_last) begin
						valid_s1 <= 1'b0;
						count_q  <= count_q - CNT_W'(1);
						state_q  <= S_RESP;
					end
				end
				S_APPEND: begin
					count_q      <= count_q + CNT_W'(1);
					res_status_q <= ST_OK;
					res_entry_q  <= '{key: key_q, client: client_q, pri: pri_q};
					state_q      <= S_RESP;
				end
				S_LIST: begin
					if (list_adv) begin
						valid_s1 <= ram_rd_en;
						idx_s1   <= rd_idx_q[IDX_W-1:0];
					end
					if (list_emit) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_OK;
						out_entry_q  <= rd_entry;
						out_pos_q    <= pos_q;
						out_count_q  <= count_q;
						out_last_q   <= list_final;
						pos_q        <= pos_q + IDX_W'(1);
					end
					if (list_emit && list_final) begin
						valid_s1 <= 1'b0;
						state_q  <= S_IDLE;
					end else if (list_adv && s1_last) begin
						// end of one priority pass, restart the walk for the next
						valid_s1 <= 1'b0;
						rd_idx_q <= '0;
						pass_q   <= pass_q + PRI_W'(1);
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_entry_q  <= res_entry_q;
						out_pos_q    <= '0;
						out_count_q  <= count_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign entry_key      = out_entry_q.key;
	assign entry_client   = out_entry_q.client;
	assign entry_priority = out_entry_q.pri;
	assign position       = POS_W'(out_pos_q);
	assign entry_count    = COUNT_W'(out_count_q);
	assign last           = out_last_q;

	// checks
	`PTT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall && (func <= FN_LIST_ALL),
		in_stall, "table took an item without going busy")
	`PTT_ASSERT_NOW(a_no_entry_on_error, out_valid && (status != ST_OK),
		entry_priority == PRI_NONE, "error result carries an entry")
	`PTT_ASSERT_NEXT(a_count_step, state_q == S_IDLE,
		(count_q == $past(count_q)) || (state_q != S_IDLE) || $past(in_valid),
		"entry count moved while idle")
	`PTT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY),
		"entry count above capacity")

endmodule

// ===== hw/rtl/ptt_ram.sv =====
module ptt_ram #(
	parameter int WIDTH = 98,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port; read data holds without rd_en
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
